/* hdl/assert_macros.svh */
// Assertion macros shared by the steering controller RTL.
// Used by the top level; expects a clock named i_clk and reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock edge, masked during reset.
`define LMSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same check without masking by reset.
`define LMSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/lmsc_pkg.sv */
// Package for the line maze steering controller: class and mode codes,
// bridge patterns, steering table and saturation helpers. No dependencies.
package lmsc_pkg;

    typedef enum logic [2:0] {
        CLS_WHITE  = 3'd0,
        CLS_BLACK  = 3'd1,
        CLS_LEFT   = 3'd2,
        CLS_CENTER = 3'd3,
        CLS_RIGHT  = 3'd4
    } t_class;

    typedef enum logic [1:0] {
        MODE_FOLLOW = 2'd0,
        MODE_SPIN_L = 2'd1,
        MODE_SPIN_R = 2'd2
    } t_mode;

    localparam logic [3:0] BRIDGE_FWD    = 4'd5;
    localparam logic [3:0] BRIDGE_SPIN_L = 4'd9;
    localparam logic [3:0] BRIDGE_SPIN_R = 4'd6;

    localparam logic REG_LEFT_BASE  = 1'b0;
    localparam logic REG_RIGHT_BASE = 1'b1;

    // Patterns that keep a right spin going.
    localparam logic [7:0] PAT_SPIN_R_A = 8'hC0;
    localparam logic [7:0] PAT_SPIN_R_B = 8'h40;
    localparam logic [7:0] PAT_SPIN_R_C = 8'h60;

    localparam logic [7:0] SPIN_R_SLOWDOWN = 8'd30;

    typedef struct packed {
        t_mode       mode;
        t_class      prev_cls;
        t_class      cur_cls;
        logic [7:0]  left_duty;
        logic [7:0]  right_duty;
        logic [3:0]  bridge;
    } t_steer_state;

    typedef struct packed {
        logic              hit;
        logic signed [7:0] l_off;
        logic signed [7:0] r_off;
    } t_steer_lut;

    function automatic t_class classify(input logic [7:0] s);
        t_class c;
        case (s)
            8'h00:               c = CLS_WHITE;
            8'hFF:               c = CLS_BLACK;
            8'hF8, 8'hF0, 8'hE0: c = CLS_LEFT;
            8'h1F, 8'h0F, 8'h07: c = CLS_RIGHT;
            default:             c = CLS_CENTER;
        endcase
        return c;
    endfunction

    function automatic t_steer_lut steer_lookup(input logic [7:0] s);
        t_steer_lut e;
        e.hit = 1'b1;
        case (s)
            8'h60:   begin e.l_off = -8'sd90; e.r_off =  8'sd90; end
            8'h20:   begin e.l_off = -8'sd50; e.r_off =  8'sd60; end
            8'h30:   begin e.l_off = -8'sd40; e.r_off =  8'sd30; end
            8'h10:   begin e.l_off = -8'sd15; e.r_off =  8'sd15; end
            8'h18:   begin e.l_off =  8'sd0;  e.r_off =  8'sd0;  end
            8'h08:   begin e.l_off =  8'sd15; e.r_off = -8'sd15; end
            8'h0C:   begin e.l_off =  8'sd30; e.r_off = -8'sd40; end
            8'h04:   begin e.l_off =  8'sd60; e.r_off = -8'sd50; end
            8'h06:   begin e.l_off =  8'sd90; e.r_off = -8'sd90; end
            default: begin e.hit = 1'b0; e.l_off = 8'sd0; e.r_off = 8'sd0; end
        endcase
        return e;
    endfunction

    // base + offset, clamped to 0..255
    function automatic logic [7:0] add_sat(input logic [7:0] base,
                                           input logic signed [7:0] off);
        logic signed [9:0] sum;
        sum = $signed({2'b00, base}) + $signed({{2{off[7]}}, off});
        if (sum < 10'sd0) begin
            return 8'd0;
        end else if (sum > 10'sd255) begin
            return 8'd255;
        end else begin
            return sum[7:0];
        end
    endfunction

    function automatic logic [7:0] sub_sat(input logic [7:0] base,
                                           input logic [7:0] amt);
        return (base > amt) ? (base - amt) : 8'd0;
    endfunction

endpackage

/* hdl/line_maze_steering_controller.sv */
// Top level of the line maze steering controller: input register, steering
// state, result register and config registers. Depends on lmsc_pkg,
// lmsc_steer and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one 8-bit sensor pattern
//   per transfer. Output channel (o_out_valid / i_out_ready) returns one
//   result per input: both motor duties, bridge pins, the sample class and
//   the drive mode after that sample.
//   o_out_valid rises once an item has passed the input and result registers.
//   Throughput is one item per cycle while the receiver does not stall; the
//   steering state is updated by combinational logic between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; after that o_in_ready drops.
//   Base speeds are written through i_cfg_wr_en / i_cfg_index / i_cfg_data
//   (index 0 left, 1 right) only while the block is idle, a rule on the
//   user that the block does not enforce. Reset (synchronous, active low)
//   clears both pipeline stages, sets the mode to follow, both classes to
//   center, duties and base speeds to 0 and the bridge to forward.
`include "assert_macros.svh"

module line_maze_steering_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_sensor_bits,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_left_duty,
    output logic [7:0] o_right_duty,
    output logic [3:0] o_bridge_bits,
    output logic [2:0] o_sample_class,
    output logic [1:0] o_drive_mode,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import lmsc_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_sensor;
    t_steer_state r_state;
    t_steer_state n_state;
    t_class       n_cls;
    logic         r_out_valid;
    logic [7:0]   r_left_duty;
    logic [7:0]   r_right_duty;
    logic [3:0]   r_bridge;
    logic [2:0]   r_cls;
    logic [1:0]   r_mode;
    logic [7:0]   r_left_base;
    logic [7:0]   r_right_base;
    logic         s1_adv;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || s1_adv;

    lmsc_steer u_steer (
        .i_state       (r_state),
        .i_sensor_bits (r_sensor),
        .i_left_base   (r_left_base),
        .i_right_base  (r_right_base),
        .o_next        (n_state),
        .o_cls         (n_cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_base  <= 8'd0;
            r_right_base <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LEFT_BASE:  r_left_base  <= i_cfg_data;
                REG_RIGHT_BASE: r_right_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sensor <= i_sensor_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid        <= 1'b0;
            r_state.mode       <= MODE_FOLLOW;
            r_state.prev_cls   <= CLS_CENTER;
            r_state.cur_cls    <= CLS_CENTER;
            r_state.left_duty  <= 8'd0;
            r_state.right_duty <= 8'd0;
            r_state.bridge     <= BRIDGE_FWD;
        end else if (s1_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_in_valid) begin
            r_left_duty  <= n_state.left_duty;
            r_right_duty <= n_state.right_duty;
            r_bridge     <= n_state.bridge;
            r_cls        <= n_cls;
            r_mode       <= n_state.mode;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_duty    = r_left_duty;
    assign o_right_duty   = r_right_duty;
    assign o_bridge_bits  = r_bridge;
    assign o_sample_class = r_cls;
    assign o_drive_mode   = r_mode;

    `LMSC_ASSERT(a_spin_l_bridge, (r_state.mode == MODE_SPIN_L) |-> (r_state.bridge == BRIDGE_SPIN_L), "spin left without spin-left bridge")
    `LMSC_ASSERT(a_follow_bridge, (r_state.mode == MODE_FOLLOW) |-> (r_state.bridge == BRIDGE_FWD), "follow mode without forward bridge")
    `LMSC_ASSERT(a_state_hold, !(r_in_valid && s1_adv) |=> $stable(r_state), "steering state changed without a transfer")
    `LMSC_ASSERT(a_stage_hold, (r_in_valid && !s1_adv) |=> (r_in_valid && $stable(r_sensor)), "stalled input stage lost its item")

endmodule

/* hdl/lmsc_steer.sv */
// Next-state logic of the steering controller: classification, mode
// transitions and saturated duty update. Depends on lmsc_pkg.
module lmsc_steer (
    input  lmsc_pkg::t_steer_state i_state,
    input  logic [7:0]             i_sensor_bits,
    input  logic [7:0]             i_left_base,
    input  logic [7:0]             i_right_base,
    output lmsc_pkg::t_steer_state o_next,
    output lmsc_pkg::t_class       o_cls
);
    import lmsc_pkg::*;

    t_class     cls;
    t_class     pc;
    t_steer_lut lut;

    assign cls   = classify(i_sensor_bits);
    assign lut   = steer_lookup(i_sensor_bits);
    assign pc    = i_state.cur_cls;
    assign o_cls = cls;

    always_comb begin
        o_next = i_state;
        case (i_state.mode)
            MODE_SPIN_L: begin
                if (cls == CLS_CENTER) begin
                    o_next.mode       = MODE_FOLLOW;
                    o_next.bridge     = BRIDGE_FWD;
                    o_next.left_duty  = i_left_base;
                    o_next.right_duty = i_right_base;
                    o_next.cur_cls    = CLS_CENTER;
                end
            end
            MODE_SPIN_R: begin
                if (!(i_sensor_bits inside {PAT_SPIN_R_A, PAT_SPIN_R_B, PAT_SPIN_R_C})) begin
                    o_next.mode       = MODE_FOLLOW;
                    o_next.bridge     = BRIDGE_FWD;
                    o_next.left_duty  = i_left_base;
                    o_next.right_duty = i_right_base;
                    o_next.cur_cls    = CLS_CENTER;
                end
            end
            default: begin
                o_next.mode     = MODE_FOLLOW;
                o_next.prev_cls = pc;
                o_next.cur_cls  = cls;
                if ((cls == CLS_WHITE && (pc inside {CLS_LEFT, CLS_BLACK, CLS_CENTER}))
                    || (cls == CLS_CENTER && (pc inside {CLS_LEFT, CLS_BLACK}))) begin
                    o_next.mode       = MODE_SPIN_L;
                    o_next.bridge     = BRIDGE_SPIN_L;
                    o_next.left_duty  = i_left_base;
                    o_next.right_duty = i_right_base;
                end else if (cls == CLS_WHITE && pc == CLS_RIGHT) begin
                    o_next.mode       = MODE_SPIN_R;
                    o_next.bridge     = BRIDGE_SPIN_R;
                    o_next.left_duty  = sub_sat(i_left_base, SPIN_R_SLOWDOWN);
                    o_next.right_duty = sub_sat(i_right_base, SPIN_R_SLOWDOWN);
                end else begin
                    if (cls == CLS_CENTER && pc == CLS_RIGHT) begin
                        o_next.left_duty  = i_left_base;
                        o_next.right_duty = i_right_base;
                    end
                    if (lut.hit) begin
                        o_next.left_duty  = add_sat(i_left_base, lut.l_off);
                        o_next.right_duty = add_sat(i_right_base, lut.r_off);
                    end
                end
            end
        endcase
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for line_maze_steering_controller: directed and random sensor patterns,
// with a scoreboard class that predicts each result. Depends on lmsc_pkg and the RTL.
module testbench;
    import lmsc_pkg::*;

    localparam int LIMIT = 600000;

    typedef struct {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic [3:0] bridge;
        t_class     cls;
        t_mode      mode;
    } t_steer_result;

    class t_steer_scoreboard;
        logic [7:0]    left_base;
        logic [7:0]    right_base;
        t_mode         mode;
        t_class        prev_cls;
        t_class        cur_cls;
        logic [7:0]    left_duty;
        logic [7:0]    right_duty;
        logic [3:0]    bridge;
        t_steer_result pending[$];
        int            errors;

        function new();
            left_base  = 8'd0;
            right_base = 8'd0;
            mode       = MODE_FOLLOW;
            prev_cls   = CLS_CENTER;
            cur_cls    = CLS_CENTER;
            left_duty  = 8'd0;
            right_duty = 8'd0;
            bridge     = BRIDGE_FWD;
            errors     = 0;
        endfunction

        function void set_base(logic idx, logic [7:0] v);
            if (idx == REG_LEFT_BASE) begin
                left_base = v;
            end else begin
                right_base = v;
            end
        endfunction

        function logic [7:0] clamp8(int v);
            if (v < 0) begin
                return 8'd0;
            end else if (v > 255) begin
                return 8'd255;
            end
            return v[7:0];
        endfunction

        function t_class sort_pattern(logic [7:0] s);
            case (s)
                8'h00:               return CLS_WHITE;
                8'hFF:               return CLS_BLACK;
                8'hF8, 8'hF0, 8'hE0: return CLS_LEFT;
                8'h1F, 8'h0F, 8'h07: return CLS_RIGHT;
                default:             return CLS_CENTER;
            endcase
        endfunction

        // unlisted patterns leave the duties alone
        function void steer(logic [7:0] s);
            int  lo;
            int  ro;
            bit  hit;
            hit = 1'b1;
            case (s)
                8'h60:   begin lo = -90; ro =  90; end
                8'h20:   begin lo = -50; ro =  60; end
                8'h30:   begin lo = -40; ro =  30; end
                8'h10:   begin lo = -15; ro =  15; end
                8'h18:   begin lo =   0; ro =   0; end
                8'h08:   begin lo =  15; ro = -15; end
                8'h0C:   begin lo =  30; ro = -40; end
                8'h04:   begin lo =  60; ro = -50; end
                8'h06:   begin lo =  90; ro = -90; end
                default: begin lo =   0; ro =   0; hit = 1'b0; end
            endcase
            if (hit) begin
                left_duty  = clamp8(int'(left_base) + lo);
                right_duty = clamp8(int'(right_base) + ro);
            end
        endfunction

        function void spin_left();
            mode       = MODE_SPIN_L;
            bridge     = BRIDGE_SPIN_L;
            left_duty  = left_base;
            right_duty = right_base;
        endfunction

        function void end_spin();
            mode       = MODE_FOLLOW;
            bridge     = BRIDGE_FWD;
            left_duty  = left_base;
            right_duty = right_base;
            cur_cls    = CLS_CENTER;
        endfunction

        function void note_sample(logic [7:0] s);
            t_class        c;
            t_steer_result r;
            c = sort_pattern(s);
            if (mode == MODE_SPIN_L) begin
                if (c == CLS_CENTER) end_spin();
            end else if (mode == MODE_SPIN_R) begin
                if (s != PAT_SPIN_R_A && s != PAT_SPIN_R_B && s != PAT_SPIN_R_C) end_spin();
            end else begin
                mode     = MODE_FOLLOW;
                prev_cls = cur_cls;
                cur_cls  = c;
                if (c == CLS_WHITE) begin
                    if (prev_cls == CLS_LEFT || prev_cls == CLS_BLACK ||
                        prev_cls == CLS_CENTER) begin
                        spin_left();
                    end else if (prev_cls == CLS_RIGHT) begin
                        mode       = MODE_SPIN_R;
                        bridge     = BRIDGE_SPIN_R;
                        left_duty  = clamp8(int'(left_base) - int'(SPIN_R_SLOWDOWN));
                        right_duty = clamp8(int'(right_base) - int'(SPIN_R_SLOWDOWN));
                    end else begin
                        steer(s);
                    end
                end else if (c == CLS_CENTER &&
                             (prev_cls == CLS_LEFT || prev_cls == CLS_BLACK)) begin
                    spin_left();
                end else begin
                    if (c == CLS_CENTER && prev_cls == CLS_RIGHT) begin
                        left_duty  = left_base;
                        right_duty = right_base;
                    end
                    steer(s);
                end
            end
            r.left_duty  = left_duty;
            r.right_duty = right_duty;
            r.bridge     = bridge;
            r.cls        = c;
            r.mode       = mode;
            pending.push_back(r);
        endfunction

        function void note_miss(string what, int exp_val, int act_val);
            errors++;
            if (errors <= 10) begin
                $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [7:0] l, logic [7:0] r, logic [3:0] b,
                                   logic [2:0] c, logic [1:0] m);
            t_steer_result e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result transfer with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (l !== e.left_duty)  note_miss("left_duty", e.left_duty, l);
            if (r !== e.right_duty) note_miss("right_duty", e.right_duty, r);
            if (b !== e.bridge)     note_miss("bridge_bits", e.bridge, b);
            if (c !== e.cls)        note_miss("sample_class", e.cls, c);
            if (m !== e.mode)       note_miss("drive_mode", e.mode, m);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_sensor_bits;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_left_duty;
    logic [7:0] o_right_duty;
    logic [3:0] o_bridge_bits;
    logic [2:0] o_sample_class;
    logic [1:0] o_drive_mode;
    logic       i_cfg_wr_en;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    t_steer_scoreboard sb = new();
    bit                steady;
    int                cycles;

    line_maze_steering_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sensor_bits (i_sensor_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_duty   (o_left_duty),
        .o_right_duty  (o_right_duty),
        .o_bridge_bits (o_bridge_bits),
        .o_sample_class(o_sample_class),
        .o_drive_mode  (o_drive_mode),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_sample(input logic [7:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sensor_bits <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(s);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_bases(input logic [7:0] lb, input logic [7:0] rb);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_LEFT_BASE;
        i_cfg_data  <= lb;
        @(posedge i_clk);
        i_cfg_index <= REG_RIGHT_BASE;
        i_cfg_data  <= rb;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_base(REG_LEFT_BASE, lb);
        sb.set_base(REG_RIGHT_BASE, rb);
    endtask

    // result side: check each transfer, then pick the next ready level
    initial begin : result_side
        int stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_left_duty, o_right_duty, o_bridge_bits,
                                o_sample_class, o_drive_mode);
            end
            if (stall == 0) stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] warmup[5]  = '{8'h60, 8'h06, 8'h07, 8'h00, 8'h12};
        logic [7:0] directed[23] = '{8'h00, 8'h18, 8'hFF, 8'h18, 8'h3C, 8'h07, 8'h00,
                                     8'hC0, 8'h40, 8'h60, 8'h55, 8'hF8, 8'h00, 8'hE0,
                                     8'h3C, 8'h0F, 8'h18, 8'h20, 8'h30, 8'h10, 8'h08,
                                     8'h0C, 8'h04};
        logic [7:0] notable[19] = '{8'h00, 8'hFF, 8'hF8, 8'hF0, 8'hE0, 8'h1F, 8'h0F,
                                    8'h07, 8'h60, 8'h20, 8'h30, 8'h10, 8'h18, 8'h08,
                                    8'h0C, 8'h04, 8'h06, 8'hC0, 8'h40};
        logic [7:0] right_pats[3] = '{8'h1F, 8'h0F, 8'h07};
        logic [7:0] left_pats[4]  = '{8'hF8, 8'hF0, 8'hE0, 8'hFF};
        logic [7:0] hold_pats[3]  = '{8'hC0, 8'h40, 8'h60};
        logic [7:0] lb_set[8] = '{8'd0, 8'd255, 8'd29, 8'd30, 8'd255, 8'd0, 8'd0, 8'd0};
        logic [7:0] rb_set[8] = '{8'd0, 8'd255, 8'd31, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
        logic [7:0] upcoming[$];
        int         n;

        steady        = 1'b0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_sensor_bits <= 8'h00;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= REG_LEFT_BASE;
        i_cfg_data    <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // base speeds still at reset: negative offsets and spin-right slowdown clamp at 0
        foreach (warmup[k]) send_sample(warmup[k]);
        drain();
        set_bases(8'd250, 8'd20);
        foreach (directed[k]) send_sample(directed[k]);
        drain();

        for (int p = 5; p < 8; p++) begin
            lb_set[p] = 8'($urandom_range(0, 255));
            rb_set[p] = 8'($urandom_range(0, 255));
        end

        for (int p = 0; p < 8; p++) begin
            set_bases(lb_set[p], rb_set[p]);
            n = 0;
            while (n < 175) begin
                if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
                if (n == 90) drain();
                if (upcoming.size() == 0) begin
                    if ($urandom_range(0, 99) < 25) begin
                        case ($urandom_range(0, 2))
                            0: begin
                                upcoming.push_back(right_pats[$urandom_range(0, 2)]);
                                upcoming.push_back(8'h00);
                                repeat ($urandom_range(0, 3))
                                    upcoming.push_back(hold_pats[$urandom_range(0, 2)]);
                                upcoming.push_back(8'($urandom_range(0, 255)));
                            end
                            1: begin
                                upcoming.push_back(left_pats[$urandom_range(0, 3)]);
                                upcoming.push_back(8'h00);
                                repeat ($urandom_range(0, 3))
                                    upcoming.push_back(notable[$urandom_range(0, 7)]);
                                upcoming.push_back(8'($urandom_range(0, 255)));
                            end
                            default: begin
                                upcoming.push_back(left_pats[$urandom_range(0, 3)]);
                                upcoming.push_back(8'h18);
                                upcoming.push_back(8'($urandom_range(0, 255)));
                            end
                        endcase
                    end else if ($urandom_range(0, 99) < 70) begin
                        upcoming.push_back(notable[$urandom_range(0, 18)]);
                    end else begin
                        upcoming.push_back(8'($urandom_range(0, 255)));
                    end
                end
                send_sample(upcoming.pop_front());
                n++;
            end
            steady = 1'b0;
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/lmsc_pkg.sv
hdl/lmsc_steer.sv
hdl/line_maze_steering_controller.sv
dv/testbench.sv
